// File: hw/rtl/ecisl_pkg.sv
`timescale 1ns / 1ps

package ecisl_pkg;

    // Field widths fixed by the item formats.
    localparam int SP_W    = 16;   // set point
    localparam int TGT_W   = 14;   // set point after the divide by five
    localparam int POS_W   = 16;   // position count and speed
    localparam int CMD_W   = 8;    // drive command
    localparam int KI_W    = 8;    // integral gain
    localparam int MODE_W  = 2;    // encoder mode
    localparam int CFG_W   = 8;    // configuration write data
    localparam int CFG_A_W = 1;    // configuration register index

    // The command is clipped to plus or minus this value.
    localparam int CMD_LIMIT = 100;

    // Divide by five: multiply by ceil(2^18 / 5) and shift right by 18.
    // The result is exact for every magnitude below 2^16.
    localparam int DIV5_RECIP = 52429;
    localparam int DIV5_SHIFT = 18;

    typedef enum logic [0:0] {
        KIND_SAMPLE = 1'b0,
        KIND_STEP   = 1'b1
    } t_kind;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_KI_GAIN  = 1'b0,
        CFG_ENC_MODE = 1'b1
    } t_cfg_idx;

    localparam logic [MODE_W-1:0] ENC_MODE_COUNT = 2'd0;

endpackage

// File: hw/rtl/ecisl_in_if.sv
`timescale 1ns / 1ps

interface ecisl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic                                  enc_a;
    logic signed [ecisl_pkg::SP_W-1:0]     set_point;

    modport source (output valid, output kind, output enc_a, output set_point, input ready);
    modport sink   (input valid, input kind, input enc_a, input set_point, output ready);
endinterface

// File: hw/rtl/ecisl_out_if.sv
`timescale 1ns / 1ps

interface ecisl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ecisl_pkg::CMD_W-1:0]    drive_command;
    logic signed [ecisl_pkg::POS_W-1:0]    speed_estimate;
    logic signed [ecisl_pkg::POS_W-1:0]    count;

    modport source (output valid, output drive_command, output speed_estimate, output count,
                    input ready);
    modport sink   (input valid, input drive_command, input speed_estimate, input count,
                    output ready);
endinterface

// File: hw/rtl/ecisl_div5.sv
`timescale 1ns / 1ps

// Signed divide by five, truncating toward zero, by reciprocal multiplication
// of the magnitude.
module ecisl_div5 (
    input  logic signed [ecisl_pkg::SP_W-1:0]  i_dividend,
    output logic signed [ecisl_pkg::TGT_W-1:0] o_quotient
);

    localparam int ProdW = 2 * ecisl_pkg::SP_W;
    localparam int QmW   = ecisl_pkg::TGT_W - 1;

    logic [ecisl_pkg::SP_W-1:0] mag;
    logic [ProdW-1:0]           prod;
    logic [QmW-1:0]             qmag;

    always_comb begin
        mag  = i_dividend[ecisl_pkg::SP_W-1] ? (~i_dividend + 1'b1) : i_dividend;
        prod = ProdW'(mag) * ProdW'(ecisl_pkg::DIV5_RECIP);
        qmag = prod[ecisl_pkg::DIV5_SHIFT +: QmW];
        if (i_dividend[ecisl_pkg::SP_W-1]) begin
            o_quotient = -$signed({1'b0, qmag});
        end else begin
            o_quotient = $signed({1'b0, qmag});
        end
    end

endmodule

// File: hw/rtl/encoder_count_integral_speed_loop.sv
`timescale 1ns / 1ps

// Encoder counter with an integral speed loop.
//
// Items arrive on i_in (valid/ready). A sample item (kind 0) carries the level
// of encoder channel A; in encoder mode 0 every change of that level moves the
// position count one step in the direction of the present drive command, or
// not at all while that command is zero. A control step item (kind 1) carries
// a set point; the block divides it by five, measures speed as the position
// change since the previous step, adds ki_gain times the speed error to the
// command and clips it to -100..100. A zero scaled set point clears the command.
// Every item yields one result on o_out: command, last speed and position,
// all taken after the item's update.
//
// From acceptance to o_out.valid, the item is first registered with its set
// point already divided, then one pass of logic updates the state and loads
// the result register. One item is accepted per cycle; the single gain
// multiplier in the update pass sets the clock. When the receiver stalls,
// the result and the item behind it hold, and i_in.ready drops once both
// registers are full. Reset clears the state, empties both stages and loads
// ki_gain = 1 and encoder_mode = 0. Configuration writes (i_cfg_we) take
// effect at the next edge.
module encoder_count_integral_speed_loop (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ecisl_pkg::CFG_A_W-1:0]     i_cfg_idx,
    input  logic [ecisl_pkg::CFG_W-1:0]       i_cfg_data,
    ecisl_in_if.sink                          i_in,
    ecisl_out_if.source                       o_out
);

    localparam int PosW  = ecisl_pkg::POS_W;
    localparam int TgtW  = ecisl_pkg::TGT_W;
    localparam int CmdW  = ecisl_pkg::CMD_W;
    localparam int ErrW  = PosW + 1;
    localparam int ProdW = ErrW + ecisl_pkg::KI_W + 1;
    localparam int SumW  = ProdW + 1;
    localparam logic signed [SumW-1:0] LimPos = SumW'(ecisl_pkg::CMD_LIMIT);
    localparam logic signed [SumW-1:0] LimNeg = -LimPos;

    // Configuration registers.
    logic [ecisl_pkg::KI_W-1:0]   r_ki_gain;
    logic [ecisl_pkg::MODE_W-1:0] r_enc_mode;

    // Loop state.
    logic [PosW-1:0]              r_pos;
    logic [PosW-1:0]              r_pos_last;
    logic signed [CmdW-1:0]       r_accum;
    logic                         r_last_a;
    logic [PosW-1:0]              r_last_speed;

    // Input stage.
    logic                         r_in_vld;
    ecisl_pkg::t_kind             r_kind;
    logic                         r_enc_a;
    logic signed [TgtW-1:0]       r_tgt;

    // Result stage.
    logic                         r_out_vld;
    logic signed [CmdW-1:0]       r_out_cmd;
    logic [PosW-1:0]              r_out_speed;
    logic [PosW-1:0]              r_out_count;

    logic                         out_free;
    logic                         advance;
    logic                         in_take;
    logic signed [TgtW-1:0]       tgt_in;

    logic [PosW-1:0]              delta;
    logic signed [ErrW-1:0]       err;
    logic signed [ProdW-1:0]      prod;
    logic signed [SumW-1:0]       sum;
    logic signed [CmdW-1:0]       n_accum;
    logic [PosW-1:0]              n_pos;
    logic [PosW-1:0]              n_pos_last;
    logic                         n_last_a;
    logic [PosW-1:0]              n_last_speed;

    ecisl_div5 u_div5 (
        .i_dividend (i_in.set_point),
        .o_quotient (tgt_in)
    );

    // The result register frees when empty or when its item is taken; the
    // input stage moves into it in that same cycle.
    assign out_free   = !r_out_vld || o_out.ready;
    assign advance    = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ki_gain  <= ecisl_pkg::KI_W'(1);
            r_enc_mode <= ecisl_pkg::ENC_MODE_COUNT;
        end else if (i_cfg_we) begin
            unique case (ecisl_pkg::t_cfg_idx'(i_cfg_idx))
                ecisl_pkg::CFG_KI_GAIN:  r_ki_gain  <= i_cfg_data;
                ecisl_pkg::CFG_ENC_MODE: r_enc_mode <= i_cfg_data[ecisl_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Update pass: everything the registered item does to the state.
    always_comb begin
        n_pos        = r_pos;
        n_pos_last   = r_pos_last;
        n_accum      = r_accum;
        n_last_a     = r_last_a;
        n_last_speed = r_last_speed;

        delta = r_pos - r_pos_last;
        err   = ErrW'(r_tgt) - ErrW'($signed(delta));
        prod  = $signed({1'b0, r_ki_gain}) * err;
        sum   = SumW'(r_accum) + SumW'(prod);

        if (r_kind == ecisl_pkg::KIND_SAMPLE) begin
            if (r_enc_mode == ecisl_pkg::ENC_MODE_COUNT && r_enc_a != r_last_a) begin
                n_last_a = r_enc_a;
                if (r_accum > 0) begin
                    n_pos = r_pos + 1'b1;
                end else if (r_accum < 0) begin
                    n_pos = r_pos - 1'b1;
                end
            end
        end else begin
            n_last_speed = delta;
            n_pos_last   = r_pos;
            priority if (r_tgt == '0) begin
                n_accum = '0;
            end else if (sum > LimPos) begin
                n_accum = CmdW'(LimPos);
            end else if (sum < LimNeg) begin
                n_accum = CmdW'(LimNeg);
            end else begin
                n_accum = CmdW'(sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pos        <= '0;
            r_pos_last   <= '0;
            r_accum      <= '0;
            r_last_a     <= 1'b0;
            r_last_speed <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_pos        <= n_pos;
                r_pos_last   <= n_pos_last;
                r_accum      <= n_accum;
                r_last_a     <= n_last_a;
                r_last_speed <= n_last_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind  <= ecisl_pkg::t_kind'(i_in.kind);
            r_enc_a <= i_in.enc_a;
            r_tgt   <= tgt_in;
        end
        if (advance) begin
            r_out_cmd   <= n_accum;
            r_out_speed <= n_last_speed;
            r_out_count <= n_pos;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.drive_command  = r_out_cmd;
    assign o_out.speed_estimate = $signed(r_out_speed);
    assign o_out.count          = $signed(r_out_count);

`ifndef SYNTHESIS
    // The command never leaves its clipping range.
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accum <= CmdW'(ecisl_pkg::CMD_LIMIT)) && (r_accum >= -CmdW'(ecisl_pkg::CMD_LIMIT)))
        else $error("drive command outside its limits");

    // A stalled result freezes the loop state.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> ($stable(r_pos) && $stable(r_accum)))
        else $error("state changed while the result was stalled");

    // A control step with a zero scaled set point clears the command.
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind == ecisl_pkg::KIND_STEP && r_tgt == '0) |=> (r_accum == '0))
        else $error("zero set point did not clear the command");

    // A sample item leaves the speed and the step reference alone.
    a_sample_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind == ecisl_pkg::KIND_SAMPLE)
            |=> ($stable(r_last_speed) && $stable(r_pos_last)))
        else $error("sample item changed the speed state");

    // A held item in the input stage is never dropped.
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> r_in_vld)
        else $error("input stage lost an item");
`endif

endmodule

// File: tb/encoder_count_integral_speed_loop_tb.sv
`timescale 1ns / 1ps

module encoder_count_integral_speed_loop_tb;
    import ecisl_pkg::*;

    // A control step divides the set point by this value, truncating toward zero.
    localparam int SET_POINT_DIVISOR = 5;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES     = 8;
    // Mismatches past this many are counted but not printed.
    localparam int REPORT_LIMIT      = 10;

    // One result item as the block reports it after an update.
    typedef struct {
        logic signed [CMD_W-1:0] drive_command;
        logic signed [POS_W-1:0] speed_estimate;
        logic signed [POS_W-1:0] count;
    } loop_result_t;

    // The scoreboard keeps its own copy of the controller state and the two
    // registers. Every accepted item is applied to that copy at once, and the
    // result it must produce goes to the back of a queue. Results coming out
    // of the block are matched against the front of that queue.
    class speed_loop_scoreboard;
        logic [KI_W-1:0]    ki_gain;
        logic [MODE_W-1:0]  enc_mode;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   position_at_step;
        logic [POS_W-1:0]   speed;
        int                 command;
        logic               last_a;
        loop_result_t       pending[$];
        int                 fail_count;

        function new();
            ki_gain          = 8'd1;
            enc_mode         = ENC_MODE_COUNT;
            position         = '0;
            position_at_step = '0;
            speed            = '0;
            command          = 0;
            last_a           = 1'b0;
            fail_count       = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_KI_GAIN:  ki_gain  = data[KI_W-1:0];
                CFG_ENC_MODE: enc_mode = data[MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted item to the state copy and queues its result.
        function void note_item(t_kind kind, logic a, logic signed [SP_W-1:0] sp);
            int               target;
            logic [POS_W-1:0] delta;
            longint           err;
            longint           sum;
            loop_result_t     res;
            if (kind == KIND_SAMPLE) begin
                // Only a level change counts, and only in the counting mode.
                // The direction follows the sign of the present command.
                if (enc_mode == ENC_MODE_COUNT && a !== last_a) begin
                    if (command > 0)
                        position = position + 1'b1;
                    else if (command < 0)
                        position = position - 1'b1;
                    last_a = a;
                end
            end else begin
                target           = int'(sp) / SET_POINT_DIVISOR;
                delta            = position - position_at_step;
                speed            = delta;
                position_at_step = position;
                // Wide sum, so the command saturates instead of wrapping.
                err = longint'(target) - longint'($signed(delta));
                sum = longint'(command) + longint'(ki_gain) * err;
                if (sum > CMD_LIMIT)
                    sum = CMD_LIMIT;
                else if (sum < -CMD_LIMIT)
                    sum = -CMD_LIMIT;
                command = (target == 0) ? 0 : int'(sum);
            end
            res.drive_command  = command[CMD_W-1:0];
            res.speed_estimate = speed;
            res.count          = position;
            pending.push_back(res);
        endfunction

        function void check_result(logic signed [CMD_W-1:0] cmd,
                                   logic signed [POS_W-1:0] spd,
                                   logic signed [POS_W-1:0] cnt);
            loop_result_t want;
            if (pending.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: cmd %0d speed %0d count %0d",
                             $realtime, cmd, spd, cnt);
                return;
            end
            want = pending.pop_front();
            if (cmd !== want.drive_command || spd !== want.speed_estimate ||
                    cnt !== want.count) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: mismatch: cmd %0d/%0d speed %0d/%0d count %0d/%0d %s",
                             $realtime, want.drive_command, cmd, want.speed_estimate, spd,
                             want.count, cnt, "(expected/actual)");
            end
        endfunction

        function void check_leftovers();
            if (pending.size() != 0) begin
                fail_count += pending.size();
                $display("%0d results never arrived", pending.size());
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    ecisl_in_if  in_ch();
    ecisl_out_if out_ch();

    encoder_count_integral_speed_loop dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    speed_loop_scoreboard sb = new();

    // Largest idle gap each side may draw before its next item. Both are
    // switched between 0 and 9 now and then, so that runs of back-to-back
    // items alternate with heavily throttled stretches.
    int in_gap_max  = 0;
    int out_gap_max = 0;

    always #5 i_clk = ~i_clk;

    // Sends one item: wait a random gap, present the item at a falling edge,
    // and hold it until a rising edge finds ready high. The item stays on the
    // bus afterward, so a zero gap gives back-to-back transfers.
    task automatic send_item(t_kind kind, logic a, logic signed [SP_W-1:0] sp);
        int gap;
        gap = $urandom_range(in_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.enc_a     <= a;
        in_ch.set_point <= sp;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(kind, a, sp);
    endtask

    // Stops sending and waits until every pending result has arrived, then
    // lets the pipeline settle. Register writes happen only after this.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [KI_W-1:0] ki, logic [MODE_W-1:0] mode);
        drain();
        write_reg(CFG_KI_GAIN, CFG_W'(ki));
        write_reg(CFG_ENC_MODE, CFG_W'(mode));
    endtask

    // Set points weighted toward small speeds, where the loop actually
    // settles and the count moves, with some zero targets, mid-range values,
    // fully random words and the two extremes.
    function automatic logic signed [SP_W-1:0] pick_set_point();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $urandom_range(120) - 60;
            5:             v = $urandom_range(8) - 4;
            6, 7:          v = $urandom_range(4000) - 2000;
            8:             v = $urandom;
            default:       v = $urandom_range(1) ? 32767 : -32768;
        endcase
        return v[SP_W-1:0];
    endfunction

    // Random traffic: a control step, then a burst of encoder samples that
    // mostly toggle channel A, so the count really moves between steps. About
    // one sample in ten repeats or randomizes the level as noise. Every item
    // sent counts toward the quota.
    task automatic run_traffic(int quota);
        int   done;
        int   burst;
        logic a;
        done = 0;
        while (done < quota) begin
            if ($urandom_range(7) == 0) begin
                in_gap_max  = ($urandom_range(2) == 0) ? 0 : 9;
                out_gap_max = ($urandom_range(2) == 0) ? 0 : 9;
            end
            send_item(KIND_STEP, 1'($urandom), pick_set_point());
            done++;
            burst = $urandom_range(30);
            repeat (burst) begin
                if ($urandom_range(9) == 0)
                    a = 1'($urandom);
                else
                    a = ~sb.last_a;
                done++;
                send_item(KIND_SAMPLE, a, SP_W'($urandom));
            end
        end
    endtask

    // Result side: draw a stall, then take the next result and check it.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            stall = $urandom_range(out_gap_max);
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            sb.check_result(out_ch.drive_command, out_ch.speed_estimate, out_ch.count);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_KI_GAIN;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_SAMPLE;
        in_ch.enc_a     = 1'b0;
        in_ch.set_point = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset values written explicitly.
        configure(8'd1, ENC_MODE_COUNT);
        // With a zero command a level change is recorded but the count stays.
        send_item(KIND_SAMPLE, 1'b1, 16'sh7FFF);
        send_item(KIND_SAMPLE, 1'b0, -16'sd32768);
        // Largest set point drives the command into the positive clip.
        send_item(KIND_STEP, 1'b0, 16'sd32767);
        // Positive command: three changes count up, a repeated level does not.
        send_item(KIND_SAMPLE, 1'b1, -16'sd32768);
        send_item(KIND_SAMPLE, 1'b0, 16'sd0);
        send_item(KIND_SAMPLE, 1'b1, 16'sh7FFF);
        send_item(KIND_SAMPLE, 1'b1, 16'sd0);
        // Most negative set point swings the command to the negative clip.
        send_item(KIND_STEP, 1'b1, -16'sd32768);
        // Negative command counts down through zero, so the count wraps.
        send_item(KIND_SAMPLE, 1'b0, 16'sd0);
        send_item(KIND_SAMPLE, 1'b1, 16'sd0);
        send_item(KIND_SAMPLE, 1'b0, 16'sd0);
        send_item(KIND_SAMPLE, 1'b1, 16'sd0);
        // Set points of magnitude below five give a zero target and clear.
        send_item(KIND_STEP, 1'b0, 16'sd4);
        send_item(KIND_SAMPLE, 1'b0, 16'sd0);
        send_item(KIND_STEP, 1'b1, -16'sd4);
        // Truncation toward zero on both sides of zero.
        send_item(KIND_STEP, 1'b0, -16'sd7);
        send_item(KIND_STEP, 1'b0, 16'sd7);
        send_item(KIND_STEP, 1'b1, 16'sd9);

        // Top gain: a unit error already saturates in either direction.
        configure(8'd255, ENC_MODE_COUNT);
        send_item(KIND_STEP, 1'b0, 16'sd5);
        send_item(KIND_STEP, 1'b0, -16'sd5);

        // Counting disabled: level changes leave count and last level alone.
        configure(8'd1, 2'd1);
        send_item(KIND_SAMPLE, 1'b0, 16'sd0);
        send_item(KIND_SAMPLE, 1'b1, 16'sd0);
        send_item(KIND_STEP, 1'b0, 16'sd50);

        // Random phases through a spread of gains and the disabled modes 1 and 2.
        configure(8'd255, ENC_MODE_COUNT);
        run_traffic(230);
        configure(8'd0, ENC_MODE_COUNT);
        run_traffic(200);
        configure(KI_W'($urandom_range(1, 254)), 2'd1);
        run_traffic(50);
        configure(KI_W'($urandom_range(2, 20)), 2'd2);
        run_traffic(50);
        configure(8'd1, ENC_MODE_COUNT);
        run_traffic(280);
        configure(KI_W'($urandom_range(2, 12)), ENC_MODE_COUNT);
        run_traffic(280);
        configure(KI_W'($urandom), ENC_MODE_COUNT);
        run_traffic(280);

        drain();
        sb.check_leftovers();
        if (sb.fail_count == 0)
            $display("encoder_count_integral_speed_loop test passed");
        else
            $display("encoder_count_integral_speed_loop test failed");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial begin
        #5000000;
        $display("encoder_count_integral_speed_loop test failed");
        $finish;
    end

endmodule
